// File: rtl/core/vwia_pkg.sv
// shared constants and types for the vertex weld index block, hash seed and multiplier among them
package vwia_pkg;

  localparam int Capacity  = 1024;
  localparam int Slots     = 2048;
  localparam int KeyWords  = 6;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = IdxW + 1;
  localparam int SlotW     = $clog2(Slots);
  localparam int KeyAddrW  = $clog2(Capacity * KeyWords);
  localparam int WordSelW  = $clog2(KeyWords);
  localparam int OutIdxW   = 10;
  localparam int SlotDataW = IdxW + 1;
  localparam int InDataW   = 384;

  localparam logic [63:0] HashSeed = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HashMul  = 64'h0000_0100_0000_01B3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HASH_XOR,
    ST_HASH_MUL,
    ST_HASH_MIX,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_KEY_RD,
    ST_KEY_CHK,
    ST_INSERT,
    ST_SLOT_WR,
    ST_DONE
  } vwia_state_t;

  // one 32x32 partial product for the hash multiply, keyed by step
  typedef logic [1:0] vwia_mstep_t;

endpackage

// File: rtl/core/vwia_ram.sv
// generic single port ram with registered read
module vwia_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // registered read, returns the old contents on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/vertex_weld_index_assign.sv
// top level of the vertex weld index block: hash, probe, compare and insert
// usage:
//   in_ channel carries one vertex key per word: tdata holds the ten
//   32-bit float fields and the 64-bit tint word, tuser is first_of_part.
//   out_ channel returns one word per key: vertex index, new flag and
//   table full flag.
//   one key is handled at a time. the hash takes the six words in turn
//   (xor, four steps on one 32x32 multiplier, shift mix for each),
//   then each probe reads the slot ram and checks it; on an occupied slot
//   the stored key is compared one word at a time (read, check), up
//   to six words. an insert writes six key words and then the slot.
//   the next key is taken the cycle after the result is loaded, so the
//   hash and the probe chain set the throughput.
//   after reset, and on a key with first_of_part set, the slot ram is
//   swept clear one entry a cycle, all 2048 slots, before the key goes on;
//   no key is taken during the reset sweep.
//   when the receiver stalls, the result waits in the output register and
//   the next key is already taken and worked on.
module vertex_weld_index_assign (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, material_float, occlusion,
  // surf_u, surf_v, tint_and_material
  input  logic [383:0] in_tdata,
  // first_of_part
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_index, is_new, table_full, zero fill
  output logic [15:0]  out_tdata
);

  vwia_pkg::vwia_state_t state_r, state_nxt;

  logic [vwia_pkg::InDataW-1:0]  key_r;
  logic [63:0]                   h_r, h_nxt;
  logic [63:0]                   acc_r;
  logic [2:0]                    word_r;
  vwia_pkg::vwia_mstep_t         mstep_r;
  logic [vwia_pkg::SlotW-1:0]    slot_r;
  logic [vwia_pkg::SlotW:0]      probes_r;
  logic [vwia_pkg::SlotW-1:0]    clr_r;
  logic                          busy_clr_r;
  logic [vwia_pkg::CntW-1:0]     count_r;
  logic [vwia_pkg::IdxW-1:0]     hit_idx_r;

  logic [vwia_pkg::OutIdxW-1:0]  res_idx_r;
  logic                          res_new_r, res_full_r;

  logic                          ov_r;
  logic [vwia_pkg::OutIdxW-1:0]  o_idx_r;
  logic                          o_new_r, o_full_r;

  logic [31:0]                   mul_a, mul_b;
  logic [63:0]                   mul_p, mul_add;

  // memories
  logic                            s_we;
  logic [vwia_pkg::SlotW-1:0]      s_addr;
  logic [vwia_pkg::SlotDataW-1:0]  s_wdata, s_rdata;
  logic                            k_we;
  logic [vwia_pkg::KeyAddrW-1:0]   k_addr;
  logic [63:0]                     k_rdata;
  logic [63:0]                     cur_word;
  logic [vwia_pkg::IdxW-1:0]       key_idx;
  logic                            out_free;

  vwia_ram #(.Width(vwia_pkg::SlotDataW), .Depth(vwia_pkg::Slots)) u_slots (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  vwia_ram #(.Width(64), .Depth(vwia_pkg::Capacity * vwia_pkg::KeyWords)) u_keys (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(cur_word), .rdata(k_rdata)
  );

  // key word select: word 0 is pos_x:pos_y, word 5 is the tint word
  always_comb begin
    unique case (word_r)
      3'd0:    cur_word = {key_r[31:0],    key_r[63:32]};
      3'd1:    cur_word = {key_r[95:64],   key_r[127:96]};
      3'd2:    cur_word = {key_r[159:128], key_r[191:160]};
      3'd3:    cur_word = {key_r[223:192], key_r[255:224]};
      3'd4:    cur_word = {key_r[287:256], key_r[319:288]};
      default: cur_word = key_r[383:320];
    endcase
  end

  assign key_idx  = s_rdata[vwia_pkg::IdxW-1:0];
  assign out_free = !ov_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vwia_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = in_tuser ? vwia_pkg::ST_CLEAR : vwia_pkg::ST_HASH_XOR;
        end
      end
      vwia_pkg::ST_CLEAR: begin
        if (clr_r == vwia_pkg::SlotW'(vwia_pkg::Slots - 1)) begin
          state_nxt = busy_clr_r ? vwia_pkg::ST_IDLE : vwia_pkg::ST_HASH_XOR;
        end
      end
      vwia_pkg::ST_HASH_XOR: state_nxt = vwia_pkg::ST_HASH_MUL;
      vwia_pkg::ST_HASH_MUL: begin
        if (mstep_r == 2'd3) state_nxt = vwia_pkg::ST_HASH_MIX;
      end
      vwia_pkg::ST_HASH_MIX: begin
        state_nxt = (word_r == 3'(vwia_pkg::KeyWords - 1)) ?
                    vwia_pkg::ST_SLOT_RD : vwia_pkg::ST_HASH_XOR;
      end
      vwia_pkg::ST_SLOT_RD: state_nxt = vwia_pkg::ST_SLOT_CHK;
      vwia_pkg::ST_SLOT_CHK: begin
        if (!s_rdata[vwia_pkg::IdxW]) begin
          state_nxt = (count_r >= vwia_pkg::CntW'(vwia_pkg::Capacity)) ?
                      vwia_pkg::ST_DONE : vwia_pkg::ST_INSERT;
        end else begin
          state_nxt = vwia_pkg::ST_KEY_RD;
        end
      end
      vwia_pkg::ST_KEY_RD: state_nxt = vwia_pkg::ST_KEY_CHK;
      vwia_pkg::ST_KEY_CHK: begin
        if (k_rdata != cur_word) begin
          state_nxt = (probes_r == (vwia_pkg::SlotW+1)'(vwia_pkg::Slots - 1)) ?
                      vwia_pkg::ST_DONE : vwia_pkg::ST_SLOT_RD;
        end else if (word_r == 3'(vwia_pkg::KeyWords - 1)) begin
          state_nxt = vwia_pkg::ST_DONE;
        end else begin
          state_nxt = vwia_pkg::ST_KEY_RD;
        end
      end
      vwia_pkg::ST_INSERT: begin
        if (word_r == 3'(vwia_pkg::KeyWords - 1)) state_nxt = vwia_pkg::ST_SLOT_WR;
      end
      vwia_pkg::ST_SLOT_WR: state_nxt = vwia_pkg::ST_DONE;
      vwia_pkg::ST_DONE: begin
        if (out_free) state_nxt = vwia_pkg::ST_IDLE;
      end
      default: state_nxt = vwia_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    s_we    = 1'b0;
    s_addr  = slot_r;
    s_wdata = {1'b1, count_r[vwia_pkg::IdxW-1:0]};
    k_we    = 1'b0;
    k_addr  = vwia_pkg::KeyAddrW'(32'(key_idx) * vwia_pkg::KeyWords + 32'(word_r));
    unique case (state_r)
      vwia_pkg::ST_CLEAR: begin
        s_we    = 1'b1;
        s_addr  = clr_r;
        s_wdata = '0;
      end
      vwia_pkg::ST_KEY_RD: begin
        k_addr = vwia_pkg::KeyAddrW'(32'(hit_idx_r) * vwia_pkg::KeyWords + 32'(word_r));
      end
      vwia_pkg::ST_INSERT: begin
        k_we   = 1'b1;
        k_addr = vwia_pkg::KeyAddrW'(32'(count_r[vwia_pkg::IdxW-1:0]) * vwia_pkg::KeyWords
                                     + 32'(word_r));
      end
      vwia_pkg::ST_SLOT_WR: s_we = 1'b1;
      default: ;
    endcase
  end

  // hash multiply: one 32x32 partial product a step, low 64 bits kept
  always_comb begin
    mul_a = h_r[31:0];
    mul_b = vwia_pkg::HashMul[31:0];
    unique case (mstep_r)
      2'd1:    mul_a = h_r[63:32];
      2'd2:    mul_b = vwia_pkg::HashMul[63:32];
      default: ;
    endcase
  end

  // full 64-bit product of the two 32-bit halves
  assign mul_p = mul_a * mul_b;

  // cross terms only reach the upper half
  always_comb begin
    unique case (mstep_r)
      2'd0:       mul_add = mul_p;
      2'd1, 2'd2: mul_add = {mul_p[31:0], 32'd0};
      default:    mul_add = '0;
    endcase
  end

  // hash step: seed on a new key, xor in a word, shift mix
  always_comb begin
    h_nxt = h_r;
    unique case (state_r)
      vwia_pkg::ST_IDLE:     h_nxt = vwia_pkg::HashSeed;
      vwia_pkg::ST_HASH_XOR: h_nxt = h_r ^ cur_word;
      vwia_pkg::ST_HASH_MIX: h_nxt = acc_r ^ (acc_r >> 29);
      default: ;
    endcase
  end

  assign in_tready = (state_r == vwia_pkg::ST_IDLE) && !busy_clr_r;

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= vwia_pkg::ST_CLEAR;
      busy_clr_r <= 1'b1;
      clr_r      <= '0;
      count_r    <= '0;
      ov_r       <= 1'b0;
      word_r     <= '0;
      mstep_r    <= '0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      // result word valid: set when loaded, cleared when taken
      if (state_r == vwia_pkg::ST_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        vwia_pkg::ST_IDLE: begin
          key_r   <= in_tdata;
          word_r  <= '0;
          clr_r   <= '0;
          if (in_tvalid && in_tready && in_tuser) count_r <= '0;
        end
        vwia_pkg::ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == vwia_pkg::SlotW'(vwia_pkg::Slots - 1)) busy_clr_r <= 1'b0;
        end
        vwia_pkg::ST_HASH_XOR: begin
          mstep_r <= '0;
          acc_r   <= '0;
        end
        vwia_pkg::ST_HASH_MUL: begin
          mstep_r <= mstep_r + 1'b1;
          acc_r   <= acc_r + mul_add;
        end
        vwia_pkg::ST_HASH_MIX: begin
          probes_r <= '0;
          slot_r   <= h_nxt[16 +: vwia_pkg::SlotW];
          if (word_r == 3'(vwia_pkg::KeyWords - 1)) begin
            word_r <= '0;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        vwia_pkg::ST_SLOT_CHK: begin
          hit_idx_r <= key_idx;
          word_r    <= '0;
        end
        vwia_pkg::ST_KEY_CHK: begin
          if (k_rdata != cur_word) begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r + 1'b1;
            word_r   <= '0;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        vwia_pkg::ST_INSERT: begin
          word_r <= word_r + 1'b1;
        end
        vwia_pkg::ST_DONE: begin
          word_r <= '0;
        end
        default: ;
      endcase
      if (state_r == vwia_pkg::ST_SLOT_WR) count_r <= count_r + 1'b1;
    end
  end

  // result being worked out, then loaded into the output register
  always_ff @(posedge clk) begin
    unique case (state_r)
      vwia_pkg::ST_SLOT_CHK: begin
        res_idx_r  <= vwia_pkg::OutIdxW'(count_r);
        res_new_r  <= 1'b1;
        res_full_r <= 1'b0;
        if (!s_rdata[vwia_pkg::IdxW] && count_r >= vwia_pkg::CntW'(vwia_pkg::Capacity)) begin
          res_idx_r  <= '0;
          res_new_r  <= 1'b0;
          res_full_r <= 1'b1;
        end
      end
      vwia_pkg::ST_KEY_CHK: begin
        res_idx_r  <= vwia_pkg::OutIdxW'(hit_idx_r);
        res_new_r  <= 1'b0;
        res_full_r <= 1'b0;
        if (k_rdata != cur_word) begin
          res_idx_r  <= '0;
          res_full_r <= 1'b1;
        end
      end
      vwia_pkg::ST_DONE: begin
        if (out_free) begin
          o_idx_r  <= res_idx_r;
          o_new_r  <= res_new_r;
          o_full_r <= res_full_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, o_full_r, o_new_r, o_idx_r};

  // no new key while the reset sweep runs
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_clr_r |-> !in_tready)
    else $error("key taken during clear sweep");

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vwia_pkg::CntW'(vwia_pkg::Capacity))
    else $error("distinct count above capacity");

  // an insert is always followed by the slot write
  a_insert_then_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vwia_pkg::ST_INSERT && word_r == 3'(vwia_pkg::KeyWords - 1))
    |=> state_r == vwia_pkg::ST_SLOT_WR)
    else $error("insert not closed by slot write");

  // a new result never carries the full flag
  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[10] && out_tdata[11]))
    else $error("new and full flags together");

  // results only leave the done state
  a_done_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == vwia_pkg::ST_DONE)
    else $error("result raised outside done state");

endmodule

// File: bench/tb.sv
// self-checking bench for the vertex weld index block: directed table, then random parts
module tb;

  typedef struct packed {
    logic [9:0] idx;
    logic       fresh;
    logic       full;
  } weld_result_t;

  typedef struct {
    bit           first;
    logic [383:0] key;
    bit           typed;
    weld_result_t res;
  } stim_row_t;

  localparam int WatchdogLimit = 100000;
  localparam int DrainCycles   = 200;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, material_float, occlusion,
  // surf_u, surf_v, tint_and_material
  logic [383:0] in_tdata;
  // first_of_part
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // vertex_index, is_new, table_full, zero fill
  logic [15:0]  out_tdata;

  // golden copy of the weld table
  logic [383:0] kept_keys [vwia_pkg::Capacity];
  int           slot_map [vwia_pkg::Slots];
  int           distinct_keys;

  weld_result_t pending_results[$];
  int           error_count;
  int           keys_sent;
  int           in_idle_pct;
  int           out_stall_pct;
  int           quiet_cycles;

  vertex_weld_index_assign u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // hash, linear probe and insert, as the block does it
  task automatic weld_predict(input bit first, input logic [383:0] key,
                              output weld_result_t r);
    logic [63:0] w [6];
    logic [63:0] h;
    int          s;
    int          e;
    if (first) begin
      foreach (slot_map[i]) slot_map[i] = 0;
      distinct_keys = 0;
    end
    for (int i = 0; i < 5; i++) w[i] = {key[64*i +: 32], key[64*i+32 +: 32]};
    w[5] = key[383:320];
    h = vwia_pkg::HashSeed;
    for (int i = 0; i < 6; i++) begin
      h = h ^ w[i];
      h = h * vwia_pkg::HashMul;
      h = h ^ (h >> 29);
    end
    s = int'(h[26:16]);
    for (int p = 0; p < vwia_pkg::Slots; p++) begin
      e = slot_map[s];
      if (e == 0) begin
        if (distinct_keys >= vwia_pkg::Capacity) break;
        kept_keys[distinct_keys] = key;
        slot_map[s] = distinct_keys + 1;
        r = '{idx: distinct_keys[9:0], fresh: 1'b1, full: 1'b0};
        distinct_keys++;
        return;
      end else if (kept_keys[e-1] == key) begin
        r = '{idx: 10'(e - 1), fresh: 1'b0, full: 1'b0};
        return;
      end
      s = (s + 1) % vwia_pkg::Slots;
    end
    r = '{idx: 10'd0, fresh: 1'b0, full: 1'b1};
  endtask

  function automatic logic [383:0] random_key();
    logic [383:0] k;
    for (int i = 0; i < 12; i++) k[32*i +: 32] = $urandom;
    return k;
  endfunction

  // send one word, then record what it should produce
  task automatic send_key(input bit first, input logic [383:0] key,
                          input bit typed, input weld_result_t typed_res);
    weld_result_t r;
    case ((keys_sent / 160) % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 58; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 58; end
      default: begin in_idle_pct = 23; out_stall_pct = 23; end
    endcase
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= key;
    in_tuser  <= first;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    weld_predict(first, key, r);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    keys_sent++;
  endtask

  // stimulus
  initial begin
    stim_row_t    rows [13];
    logic [383:0] pool [$];
    logic [383:0] k;
    bit           first;
    int           pick;
    weld_result_t none;
    none = '0;
    rst_n = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    error_count = 0;
    keys_sent = 0;
    distinct_keys = 0;
    foreach (slot_map[i]) slot_map[i] = 0;
    rows[0]  = '{1'b1, {384{1'b0}}, 1'b1, '{10'd0, 1'b1, 1'b0}};
    rows[1]  = '{1'b0, {384{1'b1}}, 1'b1, '{10'd1, 1'b1, 1'b0}};
    rows[2]  = '{1'b0, {384{1'b0}}, 1'b1, '{10'd0, 1'b0, 1'b0}};
    rows[3]  = '{1'b0, {384{1'b1}}, 1'b1, '{10'd1, 1'b0, 1'b0}};
    rows[4]  = '{1'b0, 384'd1 << 320, 1'b1, '{10'd2, 1'b1, 1'b0}};
    rows[5]  = '{1'b0, 384'd1 << 31, 1'b0, none};
    rows[6]  = '{1'b0, {96{4'h5}}, 1'b0, none};
    rows[7]  = '{1'b0, {96{4'hA}}, 1'b0, none};
    rows[8]  = '{1'b0, {96{4'h5}}, 1'b0, none};
    rows[9]  = '{1'b1, {384{1'b1}}, 1'b1, '{10'd0, 1'b1, 1'b0}};
    rows[10] = '{1'b0, {384{1'b0}}, 1'b1, '{10'd1, 1'b1, 1'b0}};
    rows[11] = '{1'b0, {96{4'hA}}, 1'b0, none};
    rows[12] = '{1'b0, {64'd0, 32'hFFFF_FFFF, 288'd0}, 1'b0, none};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (rows[i]) send_key(rows[i].first, rows[i].key, rows[i].typed, rows[i].res);

    // hold off until the block has drained
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // one part filled past capacity, with repeats and near misses
    pool.delete();
    for (int n = 0; n < 1150; n++) begin
      pick = $urandom_range(99);
      if (n == 0 || pool.size() == 0 || pick < 85) begin
        k = random_key();
        pool.insert(pool.size(), k);
      end else if (pick < 92) begin
        k = pool[$urandom_range(pool.size() - 1)];
      end else begin
        k = pool[$urandom_range(pool.size() - 1)];
        k[$urandom_range(383)] ^= 1'b1;
      end
      send_key(n == 0, k, 1'b0, none);
    end

    // short parts with heavy reuse
    pool.delete();
    for (int n = 0; n < 790; n++) begin
      pick = $urandom_range(99);
      first = (n == 0) || (pick < 3);
      if (first) pool.delete();
      if (pool.size() == 0 || pick < 30) begin
        k = random_key();
        if (pool.size() < 40) pool.insert(pool.size(), k);
      end else if (pick < 80) begin
        k = pool[$urandom_range(pool.size() - 1)];
      end else begin
        k = pool[$urandom_range(pool.size() - 1)];
        k[$urandom_range(383)] ^= 1'b1;
      end
      send_key(first, k, 1'b0, none);
    end

    // wind down
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result check, receiver stalls and watchdog
  always @(posedge clk) begin
    weld_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", int'(out_tdata), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[9:0] != want.idx)
            report_mismatch("vertex_index", out_tdata[9:0], want.idx);
          if (out_tdata[10] != want.fresh)
            report_mismatch("is_new", out_tdata[10], want.fresh);
          if (out_tdata[11] != want.full)
            report_mismatch("table_full", out_tdata[11], want.full);
        end
      end
    end
  end

endmodule
